@@ hdl/chunked_body_deframer_assert.svh @@
// Assertion macros for the chunked body deframer.
// Needs a clock named clk in the including scope; no other dependencies.
`ifndef CHUNKED_BODY_DEFRAMER_ASSERT_SVH
`define CHUNKED_BODY_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define CBD_ASSERT_NOW(lbl, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("cbd check failed");

// next-cycle implication
`define CBD_ASSERT_NEXT(lbl, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("cbd check failed");

`endif

@@ hdl/cbd_pkg.sv @@
// Shared types, constants and hex decode for the chunked body deframer.
// No dependencies.
package cbd_pkg;

  localparam int SIZE_BITS = 32;

  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [1:0] TRAILER_LEN = 2'd2;

  typedef enum logic [1:0] {
    PH_SIZE  = 2'd0,
    PH_DATA  = 2'd1,
    PH_TRAIL = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_OVF  = 2'd2
  } kind_t;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
  } result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ hdl/cbd_in_stage.sv @@
// Input register of the chunked body deframer.
// Depends on cbd_pkg.
module cbd_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  cbd_pkg::item_t in_item,
  input  logic           advance,
  output logic           in_stall,
  output logic           held_valid,
  output cbd_pkg::item_t held_item
);

  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      held_item <= in_item;
    end
  end

endmodule

@@ hdl/cbd_parser.sv @@
// Chunk framing state machine: size line, chunk data, trailer skip, done.
// Depends on cbd_pkg.
module cbd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  cbd_pkg::item_t   item,
  output cbd_pkg::result_t res
);

  cbd_pkg::phase_t                phase, phase_next, phase_e;
  logic [cbd_pkg::SIZE_BITS-1:0] byte_count, byte_count_next, count_e, count_dec;
  logic                          hex_ended, hex_ended_next, hex_e;
  logic [1:0]                    trailer_left, trailer_left_next, trailer_e, trailer_dec;
  cbd_pkg::hex_t                 hx;
  logic                          is_cr, is_lf, count_zero, count_ovf;

  always_comb begin
    phase_e   = item.start ? cbd_pkg::PH_SIZE : phase;
    count_e   = item.start ? '0 : byte_count;
    hex_e     = item.start ? 1'b0 : hex_ended;
    trailer_e = item.start ? 2'd0 : trailer_left;
  end

  assign hx          = cbd_pkg::hex_decode(item.data);
  assign is_cr       = (item.data == cbd_pkg::CHAR_CR);
  assign is_lf       = (item.data == cbd_pkg::CHAR_LF);
  assign count_zero  = (count_e == '0);
  assign count_ovf   = (count_e[cbd_pkg::SIZE_BITS-1 -: 4] != 4'd0);
  assign count_dec   = count_e - cbd_pkg::SIZE_BITS'(1);
  assign trailer_dec = trailer_e - 2'd1;

  // next state
  always_comb begin
    phase_next        = phase_e;
    byte_count_next   = count_e;
    hex_ended_next    = hex_e;
    trailer_left_next = trailer_e;
    case (phase_e)
      cbd_pkg::PH_SIZE: begin
        if (is_cr) begin
        end else if (is_lf) begin
          if (count_zero) begin
            phase_next = cbd_pkg::PH_DONE;
          end else begin
            phase_next     = cbd_pkg::PH_DATA;
            hex_ended_next = 1'b0;
          end
        end else if (hex_e) begin
        end else if (!hx.is_hex) begin
          hex_ended_next = 1'b1;
        end else if (count_ovf) begin
          phase_next      = cbd_pkg::PH_DONE;
          byte_count_next = '0;
        end else begin
          byte_count_next = {count_e[cbd_pkg::SIZE_BITS-5:0], hx.value};
        end
      end
      cbd_pkg::PH_DATA: begin
        byte_count_next = count_dec;
        if (count_dec == '0) begin
          phase_next        = cbd_pkg::PH_TRAIL;
          trailer_left_next = cbd_pkg::TRAILER_LEN;
        end
      end
      cbd_pkg::PH_TRAIL: begin
        trailer_left_next = trailer_dec;
        if (trailer_dec == 2'd0) begin
          phase_next      = cbd_pkg::PH_SIZE;
          byte_count_next = '0;
          hex_ended_next  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // result
  always_comb begin
    res.valid = 1'b0;
    res.kind  = cbd_pkg::KIND_BYTE;
    res.data  = 8'd0;
    case (phase_e)
      cbd_pkg::PH_SIZE: begin
        if (is_cr) begin
        end else if (is_lf) begin
          if (count_zero) begin
            res.valid = fire;
            res.kind  = cbd_pkg::KIND_END;
          end
        end else if (!hex_e && hx.is_hex && count_ovf) begin
          res.valid = fire;
          res.kind  = cbd_pkg::KIND_OVF;
        end
      end
      cbd_pkg::PH_DATA: begin
        res.valid = fire;
        res.data  = item.data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= cbd_pkg::PH_SIZE;
      byte_count   <= '0;
      hex_ended    <= 1'b0;
      trailer_left <= 2'd0;
    end else if (fire) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      hex_ended    <= hex_ended_next;
      trailer_left <= trailer_left_next;
    end
  end

endmodule

@@ hdl/cbd_out_stage.sv @@
// Result register of the chunked body deframer.
// Depends on cbd_pkg.
module cbd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  cbd_pkg::result_t res,
  input  logic             out_stall,
  output logic             out_free,
  output logic             out_valid,
  output logic [7:0]       out_data,
  output logic [1:0]       out_kind
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= res.data;
      out_kind <= 2'(res.kind);
    end
  end

endmodule

@@ hdl/chunked_body_deframer.sv @@
// Top level of the chunked transfer body deframer.
// Depends on cbd_pkg, cbd_in_stage, cbd_parser, cbd_out_stage and the assert header.
//
//   channel  valid         stall         payload
//   input    byte_valid    byte_stall    start_of_body, data_byte
//   result   result_valid  result_stall  out_byte, result_kind
//
// One byte per cycle while result_stall is low; an accepted byte goes to the
// input register, and its result then loads into the result register.
// The chunk state loop (size count, phase) closes through the state registers in cbd_parser.
// rst is synchronous and clears both valid flags and the framing state.
// A stalled result holds a full input register, which stalls the input.
module chunked_body_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic       start_of_body,
  input  logic [7:0] data_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic [1:0] result_kind
);

  cbd_pkg::item_t   in_item, held_item;
  cbd_pkg::result_t res;
  logic             held_valid, out_free, fire;

  assign in_item.start = start_of_body;
  assign in_item.data  = data_byte;
  assign fire          = held_valid && out_free;

  cbd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (byte_valid),
    .in_item    (in_item),
    .advance    (out_free),
    .in_stall   (byte_stall),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  cbd_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (held_item),
    .res  (res)
  );

  cbd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .out_stall (result_stall),
    .out_free  (out_free),
    .out_valid (result_valid),
    .out_data  (out_byte),
    .out_kind  (result_kind)
  );

`include "chunked_body_deframer_assert.svh"

  `CBD_ASSERT_NOW(a_marker_zero, rst,
    result_valid && result_kind != 2'(cbd_pkg::KIND_BYTE), out_byte == 8'd0)
  `CBD_ASSERT_NOW(a_kind_legal, rst, result_valid, result_kind <= 2'(cbd_pkg::KIND_OVF))
  `CBD_ASSERT_NEXT(a_accept_held, rst, byte_valid && !byte_stall, held_valid)
  `CBD_ASSERT_NEXT(a_reset_empty, 1'b0, rst, !result_valid && !held_valid)

endmodule
